>>> hw/rtl/rrts_pkg.sv
`timescale 1ns / 1ps

package rrts_pkg;

   localparam int TIME_W  = 16;
   localparam int BURST_W = 16;
   localparam int TASK_W  = 5;

   localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_TICK = 1'b1;

   typedef logic [TIME_W-1:0]  time_type;
   typedef logic [BURST_W-1:0] burst_type;
   typedef logic [TASK_W-1:0]  task_type;

   typedef struct packed {
      logic empty;
      logic full;
   } fifo_status_type;

endpackage

>>> hw/rtl/rrts_channels.sv
`timescale 1ns / 1ps

interface rrts_req_channel;
   logic                 valid;
   logic                 ready;
   logic                 operation;
   rrts_pkg::time_type   arrival_time;
   rrts_pkg::burst_type  burst_length;

   modport source (output valid, output operation, output arrival_time,
                   output burst_length, input ready);
   modport sink   (input valid, input operation, input arrival_time,
                   input burst_length, output ready);
endinterface

interface rrts_rsp_channel;
   logic                valid;
   logic                ready;
   rrts_pkg::task_type  task_index;
   logic                idle;
   logic                finished;
   rrts_pkg::time_type  slot_time;

   modport source (output valid, output task_index, output idle, output finished,
                   output slot_time, input ready);
   modport sink   (input valid, input task_index, input idle, input finished,
                   input slot_time, output ready);
endinterface

>>> hw/rtl/round_robin_tick_scheduler.sv
`timescale 1ns / 1ps
// Channel  Dir  Transaction
// req_if   in   operation, arrival_time, burst_length (load a task or advance a tick)
// rsp_if   out  task_index, idle, finished, slot_time (one per tick)
//
// A load is written into the task table as it is accepted. The length of a tick
// is set by the arrival scan, which runs twice on the first tick: one
// task table read and one compare per entry through a single compare unit.
// Reset is synchronous and clears the queue pointers, task count and time.
// A held result stalls a tick only at its end, and no load goes in meanwhile.

module round_robin_tick_scheduler #(
   parameter int MAX_TASKS = 32
) (
   input  logic               clock,
   input  logic               reset,
   rrts_req_channel.sink      req_if,
   rrts_rsp_channel.source    rsp_if
);

   localparam int IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
   localparam int CW = $clog2(MAX_TASKS + 1);
   localparam logic [CW-1:0] FULL_CNT = CW'(MAX_TASKS);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_SCAN  = 3'd1;
   localparam logic [2:0] S_POP   = 3'd2;
   localparam logic [2:0] S_RDREM = 3'd3;
   localparam logic [2:0] S_UPD   = 3'd4;
   localparam logic [2:0] S_REQ   = 3'd5;
   localparam logic [2:0] S_DONE  = 3'd6;

   logic [2:0]          state_ff, state_in;
   logic [CW-1:0]       loaded_ff, loaded_in;
   rrts_pkg::time_type  time_ff, time_in;
   rrts_pkg::time_type  slot_ff, slot_in;
   rrts_pkg::time_type  target_ff, target_in;
   logic [CW-1:0]       scan_ff, scan_in;
   logic                first_ff, first_in;
   logic                cmp_vld_ff, cmp_vld_in;
   logic [IW-1:0]       cmp_idx_ff, cmp_idx_in;
   logic [IW-1:0]       idx_ff, idx_in;
   logic                idle_ff, idle_in;
   logic                fin_ff, fin_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rrts_pkg::task_type  rsp_task_ff, rsp_task_in;
   logic                rsp_idle_ff, rsp_idle_in;
   logic                rsp_fin_ff, rsp_fin_in;
   rrts_pkg::time_type  rsp_slot_ff, rsp_slot_in;

   logic                req_accept;
   logic                load_en;
   logic                arr_rd_en;
   rrts_pkg::time_type  arr_rdata;
   logic                rem_rd_en;
   rrts_pkg::burst_type rem_rdata;
   logic                rem_wr_en;
   rrts_pkg::burst_type rem_dec;
   logic                push;
   logic [IW-1:0]       push_idx;
   logic                pop;
   logic [IW-1:0]       pop_idx;
   logic                after_disp;
   rrts_pkg::fifo_status_type fifo_status;

   assign req_if.ready = (state_ff == S_IDLE);
   assign req_accept   = req_if.valid && req_if.ready;
   assign load_en      = req_accept && (req_if.operation == rrts_pkg::OP_LOAD)
                         && (loaded_ff != FULL_CNT);
   assign rem_dec      = (rem_rdata == '0) ? '0 : rem_rdata - 1'b1;

   rrts_task_table #(
      .MAX_TASKS (MAX_TASKS),
      .IW        (IW)
   ) u_table (
      .clock        (clock),
      .load_en      (load_en),
      .load_addr    (loaded_ff[IW-1:0]),
      .load_arrival (req_if.arrival_time),
      .load_burst   (req_if.burst_length),
      .arr_rd_en    (arr_rd_en),
      .arr_rd_addr  (scan_ff[IW-1:0]),
      .arr_rdata    (arr_rdata),
      .rem_rd_en    (rem_rd_en),
      .rem_rd_addr  (pop_idx),
      .rem_rdata    (rem_rdata),
      .rem_wr_en    (rem_wr_en),
      .rem_wr_addr  (idx_ff),
      .rem_wr_data  (rem_dec)
   );

   rrts_ready_fifo #(
      .MAX_TASKS (MAX_TASKS),
      .IW        (IW),
      .CW        (CW)
   ) u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_idx (push_idx),
      .pop      (pop),
      .pop_idx  (pop_idx),
      .status   (fifo_status)
   );

   always_comb begin
      state_in     = state_ff;
      loaded_in    = loaded_ff;
      time_in      = time_ff;
      slot_in      = slot_ff;
      target_in    = target_ff;
      scan_in      = scan_ff;
      first_in     = first_ff;
      cmp_vld_in   = 1'b0;
      cmp_idx_in   = cmp_idx_ff;
      idx_in       = idx_ff;
      idle_in      = idle_ff;
      fin_in       = fin_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      rsp_task_in  = rsp_task_ff;
      rsp_idle_in  = rsp_idle_ff;
      rsp_fin_in   = rsp_fin_ff;
      rsp_slot_in  = rsp_slot_ff;
      arr_rd_en    = 1'b0;
      rem_rd_en    = 1'b0;
      rem_wr_en    = 1'b0;
      push         = 1'b0;
      push_idx     = idx_ff;
      pop          = 1'b0;
      after_disp   = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (load_en) begin
               loaded_in = loaded_ff + 1'b1;
            end
            if (req_accept && (req_if.operation == rrts_pkg::OP_TICK)) begin
               slot_in = time_ff;
               if (time_ff == '0) begin
                  target_in = '0;
                  scan_in   = '0;
                  first_in  = 1'b1;
                  state_in  = S_SCAN;
               end else begin
                  state_in  = S_POP;
               end
            end
         end
         S_SCAN: begin
            if (cmp_vld_ff && (arr_rdata == target_ff)) begin
               push     = 1'b1;
               push_idx = cmp_idx_ff;
            end
            if (scan_ff < loaded_ff) begin
               arr_rd_en  = 1'b1;
               cmp_vld_in = 1'b1;
               cmp_idx_in = scan_ff[IW-1:0];
               scan_in    = scan_ff + 1'b1;
            end else if (!cmp_vld_ff) begin
               state_in = first_ff ? S_POP : S_REQ;
            end
         end
         S_POP: begin
            if (fifo_status.empty) begin
               idle_in    = 1'b1;
               fin_in     = 1'b0;
               idx_in     = '0;
               after_disp = 1'b1;
            end else begin
               pop      = 1'b1;
               idle_in  = 1'b0;
               state_in = S_RDREM;
            end
         end
         S_RDREM: begin
            idx_in    = pop_idx;
            rem_rd_en = 1'b1;
            state_in  = S_UPD;
         end
         S_UPD: begin
            rem_wr_en  = 1'b1;
            fin_in     = (rem_dec == '0);
            after_disp = 1'b1;
         end
         S_REQ: begin
            push     = !idle_ff && !fin_ff;
            push_idx = idx_ff;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_valid_in = 1'b1;
               rsp_task_in  = idle_ff ? '0 : rrts_pkg::task_type'(idx_ff);
               rsp_idle_in  = idle_ff;
               rsp_fin_in   = fin_ff;
               rsp_slot_in  = slot_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // next-tick arrival scan, skipped once time has saturated
      if (after_disp) begin
         if (slot_ff != rrts_pkg::TIME_MAX) begin
            target_in = slot_ff + 1'b1;
            time_in   = slot_ff + 1'b1;
            scan_in   = '0;
            first_in  = 1'b0;
            state_in  = S_SCAN;
         end else begin
            state_in  = S_REQ;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         loaded_ff    <= '0;
         time_ff      <= '0;
         cmp_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         loaded_ff    <= loaded_in;
         time_ff      <= time_in;
         cmp_vld_ff   <= cmp_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff     <= slot_in;
      target_ff   <= target_in;
      scan_ff     <= scan_in;
      first_ff    <= first_in;
      cmp_idx_ff  <= cmp_idx_in;
      idx_ff      <= idx_in;
      idle_ff     <= idle_in;
      fin_ff      <= fin_in;
      rsp_task_ff <= rsp_task_in;
      rsp_idle_ff <= rsp_idle_in;
      rsp_fin_ff  <= rsp_fin_in;
      rsp_slot_ff <= rsp_slot_in;
   end

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.task_index = rsp_task_ff;
   assign rsp_if.idle       = rsp_idle_ff;
   assign rsp_if.finished   = rsp_fin_ff;
   assign rsp_if.slot_time  = rsp_slot_ff;

endmodule

>>> hw/rtl/rrts_task_table.sv
`timescale 1ns / 1ps

module rrts_task_table #(
   parameter int MAX_TASKS = 32,
   parameter int IW        = 5
) (
   input  logic                 clock,
   input  logic                 load_en,
   input  logic [IW-1:0]        load_addr,
   input  rrts_pkg::time_type   load_arrival,
   input  rrts_pkg::burst_type  load_burst,
   input  logic                 arr_rd_en,
   input  logic [IW-1:0]        arr_rd_addr,
   output rrts_pkg::time_type   arr_rdata,
   input  logic                 rem_rd_en,
   input  logic [IW-1:0]        rem_rd_addr,
   output rrts_pkg::burst_type  rem_rdata,
   input  logic                 rem_wr_en,
   input  logic [IW-1:0]        rem_wr_addr,
   input  rrts_pkg::burst_type  rem_wr_data
);

   rrts_pkg::time_type  arrival_mem   [MAX_TASKS];
   rrts_pkg::burst_type remaining_mem [MAX_TASKS];
   rrts_pkg::time_type  arr_rdata_ff;
   rrts_pkg::burst_type rem_rdata_ff;

   always_ff @(posedge clock) begin
      if (load_en) begin
         arrival_mem[load_addr] <= load_arrival;
      end
      if (arr_rd_en) begin
         arr_rdata_ff <= arrival_mem[arr_rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (load_en) begin
         remaining_mem[load_addr] <= load_burst;
      end else if (rem_wr_en) begin
         remaining_mem[rem_wr_addr] <= rem_wr_data;
      end
      if (rem_rd_en) begin
         rem_rdata_ff <= remaining_mem[rem_rd_addr];
      end
   end

   assign arr_rdata = arr_rdata_ff;
   assign rem_rdata = rem_rdata_ff;

endmodule

>>> hw/rtl/rrts_ready_fifo.sv
`timescale 1ns / 1ps

module rrts_ready_fifo #(
   parameter int MAX_TASKS = 32,
   parameter int IW        = 5,
   parameter int CW        = 6
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  logic [IW-1:0]             push_idx,
   input  logic                      pop,
   output logic [IW-1:0]             pop_idx,
   output rrts_pkg::fifo_status_type status
);

   localparam logic [IW-1:0] LAST_PTR = IW'(MAX_TASKS - 1);
   localparam logic [CW-1:0] FULL_CNT = CW'(MAX_TASKS);

   logic [IW-1:0] fifo_mem [MAX_TASKS];
   logic [IW-1:0] head_ff, head_in;
   logic [IW-1:0] tail_ff, tail_in;
   logic [CW-1:0] fill_ff, fill_in;
   logic [IW-1:0] rdata_ff;
   logic          do_push;
   logic          do_pop;

   assign status.empty = (fill_ff == '0);
   assign status.full  = (fill_ff == FULL_CNT);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;

   always_comb begin
      head_in = head_ff;
      tail_in = tail_ff;
      fill_in = fill_ff;
      if (do_push) begin
         tail_in = (tail_ff == LAST_PTR) ? '0 : tail_ff + 1'b1;
      end
      if (do_pop) begin
         head_in = (head_ff == LAST_PTR) ? '0 : head_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
         fill_ff <= '0;
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         fifo_mem[tail_ff] <= push_idx;
      end
      if (do_pop) begin
         rdata_ff <= fifo_mem[head_ff];
      end
   end

   assign pop_idx = rdata_ff;

endmodule

>>> tb/round_robin_tick_scheduler_tb.sv
`timescale 1ns / 1ps

module round_robin_tick_scheduler_tb;

   localparam int TABLE_DEPTH   = 32;
   localparam int RANDOM_ITEMS  = 650;
   localparam int HOLD_CYCLES   = 400;
   localparam int DRAIN_CYCLES  = 80;
   localparam int CYCLE_LIMIT   = 200000;

   typedef struct {
      rrts_pkg::task_type task_index;
      logic               idle;
      logic               finished;
      rrts_pkg::time_type slot_time;
   } slot_result_type;

   class slot_tracker_type;
      rrts_pkg::time_type  arrival_of[TABLE_DEPTH];
      rrts_pkg::burst_type left_of[TABLE_DEPTH];
      rrts_pkg::task_type  ready_q[$];
      slot_result_type     pending[$];
      int                  loaded;
      rrts_pkg::time_type  slot_now;
      int                  errors;

      function new();
         loaded   = 0;
         slot_now = '0;
         errors   = 0;
      endfunction

      function void enqueue_arrivals(rrts_pkg::time_type t);
         for (int i = 0; i < loaded; i++) begin
            if (arrival_of[i] == t && ready_q.size() < TABLE_DEPTH) begin
               ready_q.push_back(rrts_pkg::task_type'(i));
            end
         end
      endfunction

      function void note_request(logic op, rrts_pkg::time_type arr,
                                 rrts_pkg::burst_type len);
         slot_result_type r;
         if (op == rrts_pkg::OP_LOAD) begin
            if (loaded < TABLE_DEPTH) begin
               arrival_of[loaded] = arr;
               left_of[loaded]    = len;
               loaded++;
            end
            return;
         end
         r.slot_time  = slot_now;
         r.idle       = 1'b1;
         r.finished   = 1'b0;
         r.task_index = '0;
         if (slot_now == '0) begin
            enqueue_arrivals('0);
         end
         if (ready_q.size() > 0) begin
            r.idle       = 1'b0;
            r.task_index = ready_q.pop_front();
            if (left_of[r.task_index] != '0) begin
               left_of[r.task_index]--;
            end
            r.finished = (left_of[r.task_index] == '0);
         end
         if (slot_now != rrts_pkg::TIME_MAX) begin
            enqueue_arrivals(slot_now + 1'b1);
            slot_now++;
         end
         if (!r.idle && !r.finished && ready_q.size() < TABLE_DEPTH) begin
            ready_q.push_back(r.task_index);
         end
         pending.push_back(r);
      endfunction

      function void check_slot(rrts_pkg::task_type idx, logic idle, logic fin,
                               rrts_pkg::time_type st);
         slot_result_type e;
         if (pending.size() == 0) begin
            $error("unexpected transaction: slot_time %0d task_index %0d", st, idx);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (e.task_index !== idx) begin
            $error("task_index: expected %0d, actual %0d", e.task_index, idx);
            errors++;
         end
         if (e.idle !== idle) begin
            $error("idle: expected %0d, actual %0d", e.idle, idle);
            errors++;
         end
         if (e.finished !== fin) begin
            $error("finished: expected %0d, actual %0d", e.finished, fin);
            errors++;
         end
         if (e.slot_time !== st) begin
            $error("slot_time: expected %0d, actual %0d", e.slot_time, st);
            errors++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   rrts_req_channel req_if();
   rrts_rsp_channel rsp_if();

   round_robin_tick_scheduler #(
      .MAX_TASKS(TABLE_DEPTH)
   ) uut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   slot_tracker_type board = new();

   bit long_hold = 1'b0;
   int ticks_sent;
   int loads_sent;
   int burst_left;
   int cycles = 0;

   initial begin
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("round_robin_tick_scheduler: mismatch");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_if.valid && req_if.ready) begin
            board.note_request(req_if.operation, req_if.arrival_time, req_if.burst_length);
         end
         if (rsp_if.valid && rsp_if.ready) begin
            board.check_slot(rsp_if.task_index, rsp_if.idle, rsp_if.finished,
                             rsp_if.slot_time);
         end
      end
   end

   // receiver: random stall modes in stretches, plus one long hold on request
   initial begin : rsp_drive
      int span;
      int mode;
      int k;
      bit hold_done;
      hold_done = 1'b0;
      rsp_if.ready = 1'b0;
      wait (reset === 1'b0);
      @(posedge clock);
      forever begin
         if (long_hold && !hold_done) begin
            hold_done = 1'b1;
            rsp_if.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         mode = $urandom_range(0, 3);
         span = $urandom_range(4, 48);
         for (k = 0; k < span; k++) begin
            case (mode)
               0: rsp_if.ready <= 1'b1;
               1: rsp_if.ready <= ($urandom_range(0, 3) != 0);
               2: rsp_if.ready <= ($urandom_range(0, 1) == 1);
               default: rsp_if.ready <= ((k % 6) < 2);
            endcase
            @(posedge clock);
         end
      end
   end

   task automatic push_item(logic op, rrts_pkg::time_type arr, rrts_pkg::burst_type len);
      int gap;
      if (burst_left == 0) begin
         if ($urandom_range(0, 3) == 0) begin
            burst_left = $urandom_range(20, 60);
         end else begin
            burst_left = $urandom_range(1, 12);
            gap = $urandom_range(0, 12);
            if (gap > 0) begin
               req_if.valid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
      end
      burst_left--;
      req_if.valid        <= 1'b1;
      req_if.operation    <= op;
      req_if.arrival_time <= arr;
      req_if.burst_length <= len;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      if (op == rrts_pkg::OP_TICK) begin
         ticks_sent++;
      end else begin
         loads_sent++;
      end
   endtask

   task automatic send_tick();
      push_item(rrts_pkg::OP_TICK, rrts_pkg::time_type'($urandom),
                rrts_pkg::burst_type'($urandom));
   endtask

   task automatic send_load(rrts_pkg::time_type arr, rrts_pkg::burst_type len);
      push_item(rrts_pkg::OP_LOAD, arr, len);
   endtask

   function automatic rrts_pkg::time_type time_ahead(int offset);
      int t;
      t = ((ticks_sent > int'(rrts_pkg::TIME_MAX)) ? int'(rrts_pkg::TIME_MAX) : ticks_sent)
          + offset;
      return (t > int'(rrts_pkg::TIME_MAX)) ? rrts_pkg::TIME_MAX : rrts_pkg::time_type'(t);
   endfunction

   initial begin : stimulus
      int r;
      int load_pct;
      req_if.valid        = 1'b0;
      req_if.operation    = rrts_pkg::OP_LOAD;
      req_if.arrival_time = '0;
      req_if.burst_length = '0;
      ticks_sent = 0;
      loads_sent = 0;
      burst_left = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // two arrivals at tick 0 in load order, one of them with zero burst
      send_load('0, '0);
      send_load('0, rrts_pkg::burst_type'(2));
      send_load(rrts_pkg::time_type'(1), rrts_pkg::burst_type'(1));
      repeat (8) send_tick();
      // arrival already scanned: never runs
      send_load('0, rrts_pkg::burst_type'(5));
      repeat (2) send_tick();

      // last arrival tick, longest burst
      send_load(rrts_pkg::TIME_MAX, '1);
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == 150) begin
            long_hold = 1'b1;
         end
         load_pct = (loads_sent < TABLE_DEPTH) ? 10 : 3;
         r = $urandom_range(0, 99);
         if (r < load_pct) begin
            if ($urandom_range(0, 9) != 0) begin
               send_load(time_ahead($urandom_range(0, 12)),
                         rrts_pkg::burst_type'($urandom_range(1, 20)));
            end else begin
               send_load(rrts_pkg::time_type'($urandom),
                         rrts_pkg::burst_type'($urandom_range(1, 65535)));
            end
         end else begin
            send_tick();
         end
      end
      req_if.valid <= 1'b0;

      @(posedge clock);
      while (board.pending.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.errors == 0) begin
         $display("round_robin_tick_scheduler: match");
      end else begin
         $display("round_robin_tick_scheduler: mismatch");
      end
      $finish;
   end

endmodule
